>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Command codes carried by each input item
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  localparam int TICK_W      = 16;
  localparam int CFG_W       = 16;
  localparam int BYTE_BITS   = 8;
  localparam int PHASE_W     = 5;
  localparam int COND_PHASES = 3;
  localparam int BYTE_PHASES = 19;

  localparam logic [CFG_W-1:0] TPP_RESET = CFG_W'(5);
  localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_W) - 64'd1);

  // Byte-phase landmarks: data phases end before 2*BYTE_BITS, ACK high phase at 2*BYTE_BITS+1
  localparam logic [PHASE_W-1:0] DATA_PHASES = PHASE_W'(2 * BYTE_BITS);
  localparam logic [PHASE_W-1:0] ACK_PHASE   = PHASE_W'(2 * BYTE_BITS + 1);

  // One result item
  typedef struct packed {
    logic                 scl;
    logic                 sda_out;
    logic                 busy;
    logic                 done;
    logic                 ack;
    logic [BYTE_BITS-1:0] rx;
  } res_t;

  // Phase length: zero acts as one, saturate at the tick counter range
  function automatic logic [TICK_W-1:0] phase_len(input logic [CFG_W-1:0] tpp);
    logic [31:0] len;
    len = 32'(tpp);
    if (len == 32'd0) len = 32'd1;
    if (len > TICK_MAX) len = TICK_MAX;
    return len[TICK_W-1:0];
  endfunction

endpackage

>>> rtl/i2cm_core.sv
module i2cm_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [2:0]                          cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0]      tx_byte,
  input  logic                                sda_in,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::CFG_W-1:0]          cfg_wdata,
  output i2cm_pkg::res_t                      res
);

  logic [i2cm_pkg::CFG_W-1:0]     ticks_per_phase;
  logic [i2cm_pkg::PHASE_W-1:0]   phase_step, phase_step_next;
  logic [i2cm_pkg::TICK_W-1:0]    tick_count, tick_count_next;
  i2cm_pkg::cmd_t                 active_cmd, active_cmd_next;
  logic [i2cm_pkg::BYTE_BITS-1:0] shift_reg, shift_reg_next;
  logic [i2cm_pkg::BYTE_BITS-1:0] rx_shift, rx_shift_next;
  logic                           scl_level, scl_level_next;
  logic                           sda_level, sda_level_next;
  logic                           ack_flag, ack_flag_next;
  logic                           done_next;

  logic [i2cm_pkg::PHASE_W-1:0]   k;
  logic [i2cm_pkg::PHASE_W-1:0]   total;
  logic [i2cm_pkg::TICK_W-1:0]    tick_inc;
  logic                           scl_ph, sda_ph, sample;
  logic                           cmd_ok;

  assign cmd_ok = (cmd >= i2cm_pkg::CMD_START) && (cmd <= i2cm_pkg::CMD_READ_NACK);

  // Load a new command when idle, then run this tick's phase
  always_comb begin
    phase_step_next = phase_step;
    tick_count_next = tick_count;
    active_cmd_next = active_cmd;
    shift_reg_next  = shift_reg;
    rx_shift_next   = rx_shift;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_flag_next   = ack_flag;
    done_next       = 1'b0;
    scl_ph          = 1'b1;
    sda_ph          = 1'b1;
    sample          = 1'b0;
    k               = '0;
    total           = i2cm_pkg::PHASE_W'(i2cm_pkg::BYTE_PHASES);
    tick_inc        = '0;

    if (phase_step == '0 && cmd_ok) begin
      active_cmd_next = i2cm_pkg::cmd_t'(cmd);
      phase_step_next = i2cm_pkg::PHASE_W'(1);
      tick_count_next = '0;
      shift_reg_next  = tx_byte;
      if (cmd == i2cm_pkg::CMD_WRITE) ack_flag_next = 1'b0;
      if (cmd == i2cm_pkg::CMD_READ_ACK || cmd == i2cm_pkg::CMD_READ_NACK) begin
        rx_shift_next = '0;
      end
    end

    if (phase_step_next != '0) begin
      k = phase_step_next - i2cm_pkg::PHASE_W'(1);
      unique case (active_cmd_next)
        i2cm_pkg::CMD_START: begin
          scl_ph = (k < i2cm_pkg::PHASE_W'(2));
          sda_ph = (k == '0);
          total  = i2cm_pkg::PHASE_W'(i2cm_pkg::COND_PHASES);
        end
        i2cm_pkg::CMD_STOP: begin
          scl_ph = (k != '0);
          sda_ph = (k == i2cm_pkg::PHASE_W'(2));
          total  = i2cm_pkg::PHASE_W'(i2cm_pkg::COND_PHASES);
        end
        i2cm_pkg::CMD_WRITE: begin
          if (k < i2cm_pkg::DATA_PHASES) begin
            scl_ph = k[0];
            sda_ph = shift_reg_next[i2cm_pkg::BYTE_BITS-1];
          end else begin
            scl_ph = (k == i2cm_pkg::ACK_PHASE);
            sample = (k == i2cm_pkg::ACK_PHASE);
          end
        end
        default: begin
          if (k < i2cm_pkg::DATA_PHASES) begin
            scl_ph = k[0];
            sample = k[0];
          end else begin
            scl_ph = (k == i2cm_pkg::ACK_PHASE);
            sda_ph = (active_cmd_next != i2cm_pkg::CMD_READ_ACK);
          end
        end
      endcase

      scl_level_next = scl_ph;
      sda_level_next = sda_ph;
      tick_inc       = tick_count_next + i2cm_pkg::TICK_W'(1);
      tick_count_next = tick_inc;

      // Advance to the next phase at the end of this one
      if (tick_inc >= i2cm_pkg::phase_len(ticks_per_phase)) begin
        tick_count_next = '0;
        if (active_cmd_next == i2cm_pkg::CMD_WRITE) begin
          if (sample) ack_flag_next = !sda_in;
          if (k < i2cm_pkg::DATA_PHASES && k[0]) begin
            shift_reg_next = {shift_reg_next[i2cm_pkg::BYTE_BITS-2:0], 1'b0};
          end
        end else if (sample) begin
          rx_shift_next = {rx_shift_next[i2cm_pkg::BYTE_BITS-2:0], sda_in};
        end
        if (phase_step_next >= total) begin
          phase_step_next = '0;
          active_cmd_next = i2cm_pkg::CMD_NONE;
          done_next       = 1'b1;
        end else begin
          phase_step_next = phase_step_next + i2cm_pkg::PHASE_W'(1);
        end
      end
    end
  end

  // Hold the phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= i2cm_pkg::TPP_RESET;
    end else if (cfg_we) begin
      ticks_per_phase <= cfg_wdata;
    end
  end

  // Commit sequencer state once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      tick_count <= '0;
      active_cmd <= i2cm_pkg::CMD_NONE;
      shift_reg  <= '0;
      rx_shift   <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_flag   <= 1'b0;
    end else if (step) begin
      phase_step <= phase_step_next;
      tick_count <= tick_count_next;
      active_cmd <= active_cmd_next;
      shift_reg  <= shift_reg_next;
      rx_shift   <= rx_shift_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_flag   <= ack_flag_next;
    end
  end

  assign res.scl     = scl_level_next;
  assign res.sda_out = sda_level_next;
  assign res.busy    = (phase_step_next != '0);
  assign res.done    = done_next;
  assign res.ack     = ack_flag_next;
  assign res.rx      = rx_shift_next;

endmodule

>>> rtl/i2c_master_byte_engine.sv
// I2C master byte engine: every input item is one bus tick carrying a command and the
// sampled SDA level, and every item yields exactly one result item with the SCL/SDA
// drive, busy, done, ACK and received byte after that tick. One item is accepted per
// clock cycle while in_ready is high: the sequencer update is a single registered pass,
// and a two-entry output buffer (result register plus skid register) lets one more item
// be accepted while the result side stalls; in_ready drops only while both entries are full.
// Bus speed is set by ticks_per_phase (0 behaves as 1), written through cfg_we.
module i2c_master_byte_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0] tx_byte,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           scl,
  output logic                           sda_out,
  output logic                           busy_res,
  output logic                           done_res,
  output logic                           ack_seen,
  output logic [i2cm_pkg::BYTE_BITS-1:0] rx_byte,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata
);

  i2cm_pkg::res_t res, out_reg, skid_reg;
  logic           skid_valid;
  logic           in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  i2cm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_fire),
    .cmd       (cmd),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  // Move results through the output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_fire;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload paths need no reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
        if (in_fire) skid_reg <= res;
      end else if (in_fire) begin
        out_reg <= res;
      end
    end else if (in_fire) begin
      skid_reg <= res;
    end
  end

  assign scl      = out_reg.scl;
  assign sda_out  = out_reg.sda_out;
  assign busy_res = out_reg.busy;
  assign done_res = out_reg.done;
  assign ack_seen = out_reg.ack;
  assign rx_byte  = out_reg.rx;

endmodule

>>> rtl/i2cm_checker.sv
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl,
  input logic       sda_out,
  input logic       busy_res,
  input logic       done_res,
  input logic       ack_seen,
  input logic [7:0] rx_byte
);

  // A finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported together with busy");

  // Input stalls only when a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A result is pending in the cycle after any accepted item
  a_item_reaches_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scl) && $stable(sda_out)
      && $stable(busy_res) && $stable(done_res) && $stable(ack_seen) && $stable(rx_byte))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl       (scl),
  .sda_out   (sda_out),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .ack_seen  (ack_seen),
  .rx_byte   (rx_byte)
);

>>> dv/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

  localparam int HOLD_AT  = 500;
  localparam int HOLD_LEN = 300;

  typedef struct {
    logic [2:0]                     c;
    logic [i2cm_pkg::BYTE_BITS-1:0] tx;
    logic                           sd;
  } tick_item_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [2:0]                     cmd = i2cm_pkg::CMD_NONE;
  logic [i2cm_pkg::BYTE_BITS-1:0] tx_byte = '0;
  logic                           sda_in = 1'b1;
  logic                           out_valid;
  logic                           out_ready;
  logic                           scl, sda_out, busy_res, done_res, ack_seen;
  logic [i2cm_pkg::BYTE_BITS-1:0] rx_byte;
  logic                           cfg_we = 1'b0;
  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata = '0;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl       (scl),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .ack_seen  (ack_seen),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sequencer mirror: config copy and bus state
  logic [i2cm_pkg::CFG_W-1:0]     m_tpp = i2cm_pkg::TPP_RESET;
  logic [i2cm_pkg::PHASE_W-1:0]   m_step = '0;
  logic [i2cm_pkg::TICK_W-1:0]    m_tick = '0;
  i2cm_pkg::cmd_t                 m_cmd = i2cm_pkg::CMD_NONE;
  logic [i2cm_pkg::BYTE_BITS-1:0] m_shift = '0;
  logic [i2cm_pkg::BYTE_BITS-1:0] m_rx = '0;
  logic                           m_scl = 1'b1;
  logic                           m_sda = 1'b1;
  logic                           m_ack = 1'b0;

  tick_item_t     pend_q[$];
  i2cm_pkg::res_t line_q[$];

  int   tx_gap = 0;
  int   rx_gap = 0;
  logic rx_rdy = 1'b0;
  bit   calm_tx = 1'b0;
  bit   calm_rx = 1'b0;
  int   acc_cnt = 0;
  int   res_cnt = 0;
  int   err_cnt = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   gen_tpp = i2cm_pkg::TPP_RESET;
  int   gen_cnt = 0;

  task automatic bus_reset();
    m_tpp   = i2cm_pkg::TPP_RESET;
    m_step  = '0;
    m_tick  = '0;
    m_cmd   = i2cm_pkg::CMD_NONE;
    m_shift = '0;
    m_rx    = '0;
    m_scl   = 1'b1;
    m_sda   = 1'b1;
    m_ack   = 1'b0;
  endtask

  // Advance the bus sequencer by one tick and return the line state after it
  task automatic bus_tick(input logic [2:0] c, input logic [i2cm_pkg::BYTE_BITS-1:0] tx,
                          input logic sd, output i2cm_pkg::res_t r);
    logic [i2cm_pkg::PHASE_W-1:0] k;
    int                           total;
    logic [i2cm_pkg::TICK_W-1:0]  len;
    logic                         smp;
    r.done = 1'b0;
    if (m_step == 0 && c >= i2cm_pkg::CMD_START && c <= i2cm_pkg::CMD_READ_NACK) begin
      m_cmd   = i2cm_pkg::cmd_t'(c);
      m_step  = i2cm_pkg::PHASE_W'(1);
      m_tick  = '0;
      m_shift = tx;
      if (c == i2cm_pkg::CMD_WRITE) m_ack = 1'b0;
      if (c == i2cm_pkg::CMD_READ_ACK || c == i2cm_pkg::CMD_READ_NACK) m_rx = '0;
    end
    if (m_step != 0) begin
      k     = m_step - 1'b1;
      total = (m_cmd == i2cm_pkg::CMD_START || m_cmd == i2cm_pkg::CMD_STOP)
              ? i2cm_pkg::COND_PHASES : i2cm_pkg::BYTE_PHASES;
      smp   = 1'b0;
      case (m_cmd)
        i2cm_pkg::CMD_START: begin
          m_scl = (k < 2);
          m_sda = (k == 0);
        end
        i2cm_pkg::CMD_STOP: begin
          m_scl = (k != 0);
          m_sda = (k == 2);
        end
        i2cm_pkg::CMD_WRITE: begin
          if (k < i2cm_pkg::DATA_PHASES) begin
            m_scl = k[0];
            m_sda = m_shift[i2cm_pkg::BYTE_BITS-1];
          end else begin
            m_scl = (k == i2cm_pkg::ACK_PHASE);
            m_sda = 1'b1;
            smp   = (k == i2cm_pkg::ACK_PHASE);
          end
        end
        default: begin
          if (k < i2cm_pkg::DATA_PHASES) begin
            m_scl = k[0];
            m_sda = 1'b1;
            smp   = k[0];
          end else begin
            m_scl = (k == i2cm_pkg::ACK_PHASE);
            m_sda = (m_cmd != i2cm_pkg::CMD_READ_ACK);
          end
        end
      endcase
      // Zero phase length behaves as one tick
      len    = (m_tpp == 0) ? i2cm_pkg::TICK_W'(1) : i2cm_pkg::TICK_W'(m_tpp);
      m_tick = m_tick + 1'b1;
      if (m_tick >= len) begin
        m_tick = '0;
        if (m_cmd == i2cm_pkg::CMD_WRITE) begin
          if (smp) m_ack = ~sd;
          if (k < i2cm_pkg::DATA_PHASES && k[0]) m_shift = m_shift << 1;
        end else if (smp) begin
          m_rx = {m_rx[i2cm_pkg::BYTE_BITS-2:0], sd};
        end
        m_step = m_step + 1'b1;
        if (m_step > total) begin
          m_step = '0;
          m_cmd  = i2cm_pkg::CMD_NONE;
          r.done = 1'b1;
        end
      end
    end
    r.scl     = m_scl;
    r.sda_out = m_sda;
    r.busy    = (m_step != 0);
    r.ack     = m_ack;
    r.rx      = m_rx;
  endtask

  // Driver: offer pending items, predict each one at acceptance
  always @(posedge clk) begin
    int             gap;
    tick_item_t     it;
    i2cm_pkg::res_t r;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
      bus_reset();
    end else begin
      if (cfg_we) m_tpp = cfg_wdata;
      gap = tx_gap;
      if (in_valid && in_ready) begin
        bus_tick(cmd, tx_byte, sda_in, r);
        line_q.push_back(r);
        acc_cnt++;
        if (acc_cnt % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
        gap = calm_tx ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || in_ready) begin
        if (gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= gap - 1;
        end else if (pend_q.size() != 0) begin
          it = pend_q.pop_front();
          cmd      <= it.c;
          tx_byte  <= it.tx;
          sda_in   <= it.sd;
          in_valid <= 1'b1;
          tx_gap   <= 0;
        end else begin
          in_valid <= 1'b0;
          tx_gap   <= 0;
        end
      end
    end
  end

  // Receiver: draw a wait per result
  always @(posedge clk) begin
    int w;
    if (rst) begin
      rx_rdy <= 1'b0;
      rx_gap <= 0;
    end else if (out_valid && out_ready) begin
      if (res_cnt % 64 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      w = calm_rx ? 0 : $urandom_range(0, 6);
      rx_rdy <= (w == 0);
      rx_gap <= w;
    end else if (!rx_rdy) begin
      if (rx_gap <= 1) rx_rdy <= 1'b1;
      rx_gap <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Long hold-off on the result side so the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && res_cnt == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign out_ready = rx_rdy && (hold_left == 0);

  task automatic note_fault(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Monitor: compare each result with the oldest predicted line state
  always @(posedge clk) begin
    i2cm_pkg::res_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{scl, sda_out, busy_res, done_res, ack_seen, rx_byte};
      res_cnt <= res_cnt + 1;
      if (line_q.size() == 0) begin
        note_fault($sformatf("unexpected result scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h",
                             got.scl, got.sda_out, got.busy, got.done, got.ack, got.rx));
      end else begin
        want = line_q.pop_front();
        if (want.scl !== got.scl || want.sda_out !== got.sda_out || want.busy !== got.busy ||
            want.done !== got.done || want.ack !== got.ack || want.rx !== got.rx) begin
          note_fault($sformatf(
            "result %0d: want scl=%b sda=%b busy=%b done=%b ack=%b rx=%02h, got %b %b %b %b %b %02h",
            res_cnt, want.scl, want.sda_out, want.busy, want.done, want.ack, want.rx,
            got.scl, got.sda_out, got.busy, got.done, got.ack, got.rx));
        end
      end
    end
  end

  // Stimulus helpers
  function automatic int gen_len();
    return (gen_tpp == 0) ? 1 : gen_tpp;
  endfunction

  task automatic push_item(input logic [2:0] c, input logic [i2cm_pkg::BYTE_BITS-1:0] tx,
                           input logic sd);
    tick_item_t it;
    it.c  = c;
    it.tx = tx;
    it.sd = sd;
    pend_q.push_back(it);
    gen_cnt++;
  endtask

  // One primitive with fillers up to its done tick; sd_mode < 0 means random SDA
  task automatic prim(input logic [2:0] c, input logic [i2cm_pkg::BYTE_BITS-1:0] tx,
                      input int sd_mode);
    int   ticks;
    logic [2:0] fc;
    ticks = ((c == i2cm_pkg::CMD_START || c == i2cm_pkg::CMD_STOP)
             ? i2cm_pkg::COND_PHASES : i2cm_pkg::BYTE_PHASES) * gen_len();
    push_item(c, tx, (sd_mode < 0) ? 1'($urandom_range(0, 1)) : 1'(sd_mode));
    for (int i = 1; i < ticks; i++) begin
      if (i == 1) fc = i2cm_pkg::CMD_WRITE;
      else fc = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : i2cm_pkg::CMD_NONE;
      push_item(fc, 8'($urandom), (sd_mode < 0) ? 1'($urandom_range(0, 1)) : 1'(sd_mode));
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || line_q.size() != 0);
  endtask

  // Run the sequencer to idle when the phase length is short enough
  task automatic settle();
    int total;
    drain();
    if (m_step != 0 && gen_len() <= 16) begin
      total = (m_cmd == i2cm_pkg::CMD_START || m_cmd == i2cm_pkg::CMD_STOP)
              ? i2cm_pkg::COND_PHASES : i2cm_pkg::BYTE_PHASES;
      repeat ((total - m_step + 1) * gen_len())
        push_item(i2cm_pkg::CMD_NONE, 8'($urandom), 1'b1);
      drain();
    end
  endtask

  task automatic set_tpp(input int v);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= i2cm_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_tpp = v;
    settle();
  endtask

  // Mostly well-formed primitives with random content, some raw noise
  task automatic rand_phase(input int n);
    int stop_at;
    stop_at = gen_cnt + n;
    while (gen_cnt < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          push_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        prim(3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_READ_NACK)),
             8'($urandom), -1);
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0: push_item(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
            1: push_item(3'd6, 8'($urandom), 1'($urandom_range(0, 1)));
            default: push_item(3'd7, 8'($urandom), 1'($urandom_range(0, 1)));
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset phase length first
    rand_phase(150);

    // Directed: zero length acts as one, unused codes, every primitive, extremes
    set_tpp(0);
    push_item(3'd6, 8'hFF, 1'b0);
    push_item(3'd7, 8'h00, 1'b1);
    prim(i2cm_pkg::CMD_START, 8'h00, 1);
    prim(i2cm_pkg::CMD_WRITE, 8'hFF, 0);
    prim(i2cm_pkg::CMD_WRITE, 8'h00, 1);
    prim(i2cm_pkg::CMD_READ_ACK, 8'hFF, 1);
    prim(i2cm_pkg::CMD_READ_NACK, 8'h00, 0);
    prim(i2cm_pkg::CMD_STOP, 8'hFF, 1);

    set_tpp(1);
    rand_phase(250);
    set_tpp(2);
    rand_phase(200);

    // Longest phase length: the bus sits in its first phase
    set_tpp(65535);
    push_item(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0);
    repeat (80) push_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));

    set_tpp(3);
    rand_phase(200);
    set_tpp(1);
    rand_phase(250);
    set_tpp($urandom_range(4, 9));
    rand_phase(150);

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && line_q.size() == 0) begin
      $display("** i2c_master_byte_engine: PASSED **");
    end else begin
      $display("** i2c_master_byte_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("** i2c_master_byte_engine: FAILED **");
    $finish;
  end

endmodule
